### sv/sxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxf_pkg
// Shared types and constants for the STX/ETX frame receiver.
// ----------------------------------------------------------------------------
package sxf_pkg;

    localparam logic [7:0] START_MARKER_RST = 8'h02;
    localparam logic [7:0] END_MARKER_RST   = 8'h03;
    localparam logic [7:0] SYNC_CODE_RST    = 8'h16;
    localparam logic [7:0] MAX_SIZE_RST     = 8'd250;
    localparam logic [7:0] SIZE_CAP         = 8'd250;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_SYNC_CODE    = 2'd2,
        REG_MAX_SIZE     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD     = 3'd0,
        KIND_GOOD        = 3'd1,
        KIND_BAD_CHECK   = 3'd2,
        KIND_BAD_END     = 3'd3,
        KIND_NOT_SYNC    = 3'd4,
        KIND_SIZE_REJECT = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] sync_code;
        logic [7:0] max_size;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] payload_position;
        logic [7:0] command_code;
        logic [7:0] pay_len;
    } result_t;

endpackage

### sv/stx_etx_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver
// STX/ETX length-framed receiver with folded-sum checksum check.
//
// Usage:
//   s_* : one received link byte per transaction (tdata = rx_byte).
//   m_* : one result per transaction; tuser = kind, tdata carries the
//         payload byte, its position, command code and payload length.
//         Payload bytes stream out as they arrive; one verdict per frame.
//   APB : start marker, end marker, sync code and size limit at 0x0/4/8/C.
//   Throughput: one byte per cycle sustained while m_tready is high.
//   A taken byte passes through the input register, then is decoded into
//   the output register, from which its result is shown on m_*.
//   Bytes that yield no result only advance the frame state.
//   Reset: registers return to their defaults, the parser hunts for the
//   start marker, both pipeline stages empty.
//   Stall: while m_tready is low with a result held, the decode stage
//   holds and s_tready drops once the input register is full; no
//   transaction is lost or repeated.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver
    import sxf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [7:0] data_byte, [15:8] payload_position,
                                         // [23:16] command_code, [31:24] pay_len
    output logic [2:0]        m_tuser,   // [2:0] kind
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg;
    result_t    res;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [31:0] out_data_reg;
    logic       advance;
    logic       fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    sxf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sxf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= fire && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
            in_byte_reg <= s_tdata;
        if (fire && res.valid)
        begin
            out_kind_reg <= res.kind;
            out_data_reg <= {res.pay_len, res.command_code,
                             res.payload_position, res.data_byte};
        end
    end

endmodule

### sv/sxf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxf_cfg_regs
// APB register file: start/end markers, sync code and size limit.
// ----------------------------------------------------------------------------
module sxf_cfg_regs
    import sxf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= START_MARKER_RST;
            cfg_reg.end_marker   <= END_MARKER_RST;
            cfg_reg.sync_code    <= SYNC_CODE_RST;
            cfg_reg.max_size     <= MAX_SIZE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_START_MARKER: cfg_reg.start_marker <= pwdata[7:0];
                REG_END_MARKER:   cfg_reg.end_marker   <= pwdata[7:0];
                REG_SYNC_CODE:    cfg_reg.sync_code    <= pwdata[7:0];
                REG_MAX_SIZE:     cfg_reg.max_size     <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START_MARKER: prdata = {24'd0, cfg_reg.start_marker};
            REG_END_MARKER:   prdata = {24'd0, cfg_reg.end_marker};
            REG_SYNC_CODE:    prdata = {24'd0, cfg_reg.sync_code};
            REG_MAX_SIZE:     prdata = {24'd0, cfg_reg.max_size};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

### sv/sxf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxf_parser
// Frame state and per-byte decode: header, payload stream, checksum, verdict.
// ----------------------------------------------------------------------------
module sxf_parser
    import sxf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    logic        in_frame_reg,   in_frame_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_size_reg, frame_size_next;
    logic [7:0]  frame_code_reg, frame_code_next;
    logic [7:0]  frame_cmd_reg,  frame_cmd_next;
    logic [15:0] run_sum_reg,    run_sum_next;
    logic [7:0]  rx_check_reg,   rx_check_next;

    logic [7:0]  count;
    logic [7:0]  limit;
    logic [8:0]  payload_end;
    logic [8:0]  check_pos;
    logic [7:0]  folded;
    logic [15:0] sum_add;
    logic [7:0]  plen;

    assign count       = byte_count_reg + 8'd1;
    assign limit       = (cfg.max_size > SIZE_CAP) ? SIZE_CAP : cfg.max_size;
    assign payload_end = {1'b0, frame_size_reg} + 9'd3;
    assign check_pos   = {1'b0, frame_size_reg} + 9'd4;
    assign folded      = run_sum_reg[7:0] + run_sum_reg[15:8];
    assign sum_add     = run_sum_reg + {8'd0, rx_byte};
    assign plen        = frame_size_reg - 8'd1;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        frame_size_next = frame_size_reg;
        frame_code_next = frame_code_reg;
        frame_cmd_next  = frame_cmd_reg;
        run_sum_next    = run_sum_reg;
        rx_check_next   = rx_check_reg;
        res             = '0;
        res.kind        = KIND_PAYLOAD;

        if (!in_frame_reg)
        begin
            if (rx_byte == cfg.start_marker)
            begin
                in_frame_next   = 1'b1;
                byte_count_next = 8'd1;
                frame_size_next = 8'd0;
                run_sum_next    = 16'd0;
            end
        end
        else
        begin
            byte_count_next = count;
            if (count == 8'd2)
            begin
                frame_code_next = rx_byte;
            end
            else if (count == 8'd3)
            begin
                if (rx_byte == 8'd0 || rx_byte > limit)
                begin
                    in_frame_next   = 1'b0;
                    byte_count_next = 8'd0;
                    frame_size_next = 8'd0;
                    res.valid       = 1'b1;
                    res.kind        = KIND_SIZE_REJECT;
                end
                else
                begin
                    frame_size_next = rx_byte;
                    run_sum_next    = {8'd0, rx_byte};
                end
            end
            else if (frame_size_reg == 8'd0)
            begin
                in_frame_next   = 1'b0;
                byte_count_next = 8'd0;
            end
            else if (count == 8'd4)
            begin
                frame_cmd_next = rx_byte;
                run_sum_next   = sum_add;
            end
            else if ({1'b0, count} <= payload_end)
            begin
                run_sum_next         = sum_add;
                res.valid            = 1'b1;
                res.kind             = KIND_PAYLOAD;
                res.data_byte        = rx_byte;
                res.payload_position = count - 8'd5;
                res.command_code     = frame_cmd_reg;
                res.pay_len          = plen;
            end
            else if ({1'b0, count} == check_pos)
            begin
                rx_check_next = rx_byte;
            end
            else
            begin
                in_frame_next      = 1'b0;
                byte_count_next    = 8'd0;
                frame_size_next    = 8'd0;
                res.valid          = 1'b1;
                res.command_code   = frame_cmd_reg;
                res.pay_len        = plen;
                if (rx_byte != cfg.end_marker)
                    res.kind = KIND_BAD_END;
                else if (frame_code_reg != cfg.sync_code)
                    res.kind = KIND_NOT_SYNC;
                else if (folded != rx_check_reg)
                    res.kind = KIND_BAD_CHECK;
                else
                    res.kind = KIND_GOOD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= 8'd0;
            frame_size_reg <= 8'd0;
            frame_code_reg <= 8'd0;
            frame_cmd_reg  <= 8'd0;
            run_sum_reg    <= 16'd0;
            rx_check_reg   <= 8'd0;
        end
        else if (fire)
        begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
            frame_size_reg <= frame_size_next;
            frame_code_reg <= frame_code_next;
            frame_cmd_reg  <= frame_cmd_next;
            run_sum_reg    <= run_sum_next;
            rx_check_reg   <= rx_check_next;
        end
    end

endmodule

### dv/stx_etx_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_tb
// Self-checking bench for the STX/ETX frame receiver. A directed table covers
// the verdict order, size rejection and a good frame; random framed traffic
// with noise, truncated frames and corrupt trailers then runs under several
// register settings. Random results are checked against a built-in frame parser
// model, table rows against typed-in results, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_tb;
    import sxf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 135;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] payload_position;
        logic [7:0] command_code;
        logic [7:0] pay_len;
    } frame_out_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       pin;
        frame_out_t want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'h00;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic [2:0]        m_tuser;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = 32'h0;
    logic [31:0]       prdata;
    logic              pready;

    // sideband riding along with the current byte: a typed-in expectation
    logic              s_pin = 1'b0;
    frame_out_t        s_want = '0;

    stx_etx_frame_receiver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // parser model state
    cfg_t        regs_q = '{START_MARKER_RST, END_MARKER_RST, SYNC_CODE_RST, MAX_SIZE_RST};
    logic        hunt_n = 1'b0;
    logic [7:0]  frm_count = '0;
    logic [7:0]  frm_size = '0;
    logic [7:0]  frm_code = '0;
    logic [7:0]  frm_cmd = '0;
    logic [15:0] frm_sum = '0;
    logic [7:0]  frm_check = '0;

    frame_out_t  pending_q[$];
    int          cycle_cnt = 0;
    int          err_cnt = 0;
    int          payload_cnt = 0;
    int          verdict_cnt = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          settings_cnt = 1;
    bit          s_quiet = 1'b0;
    bit          m_quiet = 1'b0;

    function automatic bit parse_link_byte(input logic [7:0] b, output frame_out_t r);
        int         cnt;
        logic [7:0] lim;
        logic [7:0] folded;
        r = '0;
        r.kind = KIND_PAYLOAD;
        if (!hunt_n)
        begin
            if (b == regs_q.start_marker)
            begin
                hunt_n = 1'b1;
                frm_count = 8'd1;
                frm_size = 8'd0;
                frm_sum = 16'd0;
            end
            return 1'b0;
        end
        cnt = int'(frm_count) + 1;
        frm_count = cnt[7:0];
        if (cnt == 2)
        begin
            frm_code = b;
            return 1'b0;
        end
        if (cnt == 3)
        begin
            lim = (regs_q.max_size > SIZE_CAP) ? SIZE_CAP : regs_q.max_size;
            if (b == 8'd0 || b > lim)
            begin
                hunt_n = 1'b0;
                frm_count = 8'd0;
                frm_size = 8'd0;
                r.kind = KIND_SIZE_REJECT;
                return 1'b1;
            end
            frm_size = b;
            frm_sum = {8'h00, b};
            return 1'b0;
        end
        if (frm_size == 8'd0)
        begin
            hunt_n = 1'b0;
            frm_count = 8'd0;
            return 1'b0;
        end
        if (cnt == 4)
        begin
            frm_cmd = b;
            frm_sum = frm_sum + {8'h00, b};
            return 1'b0;
        end
        if (cnt <= int'(frm_size) + 3)
        begin
            frm_sum = frm_sum + {8'h00, b};
            r.data_byte = b;
            r.payload_position = 8'(cnt - 5);
            r.command_code = frm_cmd;
            r.pay_len = frm_size - 8'd1;
            return 1'b1;
        end
        if (cnt == int'(frm_size) + 4)
        begin
            frm_check = b;
            return 1'b0;
        end
        folded = frm_sum[7:0] + frm_sum[15:8];
        if (b != regs_q.end_marker)
            r.kind = KIND_BAD_END;
        else if (frm_code != regs_q.sync_code)
            r.kind = KIND_NOT_SYNC;
        else if (folded != frm_check)
            r.kind = KIND_BAD_CHECK;
        else
            r.kind = KIND_GOOD;
        r.command_code = frm_cmd;
        r.pay_len = frm_size - 8'd1;
        hunt_n = 1'b0;
        frm_count = 8'd0;
        frm_size = 8'd0;
        return 1'b1;
    endfunction

    task automatic report_miss(input string what, input frame_out_t want);
        string exp_s;
        err_cnt++;
        if (err_cnt <= 10)
        begin
            exp_s = $sformatf("kind=%0d data=%02h pos=%0d cmd=%02h len=%0d",
                              want.kind, want.data_byte, want.payload_position,
                              want.command_code, want.pay_len);
            $display("[%0t] %s: exp %s, got kind=%0d data=%02h pos=%0d cmd=%02h len=%0d",
                     $realtime, what, exp_s, m_tuser, m_tdata[7:0],
                     m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]);
        end
    endtask

    // monitors: register writes, accepted bytes, results
    always @(posedge clk)
    begin
        frame_out_t got;
        frame_out_t want;
        bit         hit;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("stx_etx_frame_receiver_tb: done, errors");
            $finish;
        end
        if (psel && penable && pwrite && pready)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_START_MARKER: regs_q.start_marker = pwdata[7:0];
                REG_END_MARKER:   regs_q.end_marker = pwdata[7:0];
                REG_SYNC_CODE:    regs_q.sync_code = pwdata[7:0];
                REG_MAX_SIZE:     regs_q.max_size = pwdata[7:0];
                default: ;
            endcase
        end
        if (m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                report_miss("unexpected result", '0);
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.kind == KIND_PAYLOAD)
                    payload_cnt++;
                else
                    verdict_cnt++;
                if (m_tuser != want.kind || m_tdata != {want.pay_len,
                    want.command_code, want.payload_position, want.data_byte})
                    report_miss("mismatch", want);
            end
        end
        if (s_tvalid && s_tready)
        begin
            hit = parse_link_byte(s_tdata, got);
            if (s_pin)
                pending_q.push_back(s_want);
            else if (hit)
                pending_q.push_back(got);
        end
    end

    // result side back-pressure
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) < 3)
                m_quiet = !m_quiet;
            w = m_quiet ? 0 : $urandom_range(0, 9);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic pin, input frame_out_t want);
        int w;
        w = s_quiet ? 0 : $urandom_range(0, 9);
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_pin <= pin;
        s_want <= want;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one random frame, or a noise byte, built from the current settings
    task automatic send_frame(inout bit big_done);
        logic [7:0]  fr[$];
        logic [7:0]  lim;
        logic [7:0]  sz;
        logic [7:0]  cmd;
        logic [7:0]  pb;
        logic [15:0] sum;
        int          r;
        int          cut;
        if ($urandom_range(0, 99) < 10)
            s_quiet = !s_quiet;
        if ($urandom_range(0, 99) < 10)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            bytes_sent++;
            return;
        end
        lim = (regs_q.max_size > SIZE_CAP) ? SIZE_CAP : regs_q.max_size;
        r = $urandom_range(0, 99);
        if (lim == 8'd0)
            sz = 8'($urandom_range(0, 8));
        else if (r < 5)
            sz = 8'd0;
        else if (r < 10)
            sz = lim + 8'd1;
        else if (r < 13 && !big_done)
        begin
            sz = lim;
            big_done = 1'b1;
        end
        else if (r < 16)
            sz = 8'hFF;
        else
            sz = 8'($urandom_range(1, (lim < 8) ? lim : 8));
        fr.push_back(regs_q.start_marker);
        fr.push_back(($urandom_range(0, 99) < 80) ? regs_q.sync_code
                                                  : 8'($urandom_range(0, 255)));
        fr.push_back(sz);
        if (sz != 8'd0 && sz <= lim)
        begin
            cmd = 8'($urandom_range(0, 255));
            sum = {8'h00, sz} + {8'h00, cmd};
            fr.push_back(cmd);
            for (int i = 1; i < int'(sz); i++)
            begin
                pb = 8'($urandom_range(0, 255));
                sum = sum + {8'h00, pb};
                fr.push_back(pb);
            end
            fr.push_back(($urandom_range(0, 99) < 80) ? 8'(sum[7:0] + sum[15:8])
                                                      : 8'($urandom_range(0, 255)));
            fr.push_back(($urandom_range(0, 99) < 85) ? regs_q.end_marker
                                                      : 8'($urandom_range(0, 255)));
            // truncated frame: the next frame's bytes land inside this one
            if ($urandom_range(0, 99) < 4)
            begin
                cut = $urandom_range(1, fr.size() - 1);
                while (fr.size() > cut) void'(fr.pop_back());
            end
        end
        foreach (fr[i])
            send_byte(fr[i], 1'b0, '0);
        bytes_sent += fr.size();
        frames_sent++;
    endtask

    task automatic run_phase();
        int  start_cnt;
        bit  big_done;
        start_cnt = bytes_sent;
        big_done = 1'b0;
        while (bytes_sent - start_cnt < PHASE_BYTES)
            send_frame(big_done);
        settle();
    endtask

    stim_row_t directed_rows [28];
    cfg_t      settings [7];

    initial
    begin
        cfg_t c;
        directed_rows = '{
            // good frame, size equal to start marker
            '{8'h02, 1'b0, '0}, '{8'h16, 1'b0, '0}, '{8'h02, 1'b0, '0},
            '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'h02, 1'b0, '0},
            '{8'h03, 1'b1, '{KIND_GOOD, 8'h00, 8'h00, 8'hAA, 8'h01}},
            // zero size
            '{8'h02, 1'b0, '0}, '{8'h16, 1'b0, '0},
            '{8'h00, 1'b1, '{KIND_SIZE_REJECT, 8'h00, 8'h00, 8'h00, 8'h00}},
            // bad end wins over wrong code and bad checksum
            '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h04, 1'b1, '{KIND_BAD_END, 8'h00, 8'h00, 8'hFF, 8'h00}},
            // wrong code wins over bad checksum
            '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h03, 1'b1, '{KIND_NOT_SYNC, 8'h00, 8'h00, 8'hFF, 8'h00}},
            // checksum only
            '{8'h02, 1'b0, '0}, '{8'h16, 1'b0, '0}, '{8'h01, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h03, 1'b1, '{KIND_BAD_CHECK, 8'h00, 8'h00, 8'hFF, 8'h00}}
        };
        settings = '{
            '{8'h00, 8'hFF, 8'h00, 8'd1},
            '{8'hFF, 8'h00, 8'hFF, 8'd255},
            '{8'hA5, 8'h5A, 8'h16, 8'd0},
            '{8'h7E, 8'h7E, 8'h3C, 8'd12},
            '{8'h00, 8'h00, 8'h00, 8'd0},
            '{8'h02, 8'h03, 8'h16, 8'd250},
            '{8'h00, 8'h00, 8'h00, 8'd0}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].pin, directed_rows[i].want);
        s_pin <= 1'b0;
        bytes_sent += 28;
        settle();
        run_phase();

        foreach (settings[p])
        begin
            c = settings[p];
            if (p == 4 || p == 6)
            begin
                c.start_marker = 8'($urandom_range(0, 255));
                c.end_marker = 8'($urandom_range(0, 255));
                c.sync_code = 8'($urandom_range(0, 255));
                c.max_size = 8'($urandom_range(1, 250));
            end
            apb_write(REG_START_MARKER, c.start_marker);
            apb_write(REG_END_MARKER, c.end_marker);
            apb_write(REG_SYNC_CODE, c.sync_code);
            apb_write(REG_MAX_SIZE, c.max_size);
            settings_cnt++;
            run_phase();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            err_cnt += pending_q.size();
            $display("%0d expected results never arrived", pending_q.size());
        end
        $display("covered %0d link bytes, %0d frames, %0d register settings",
                 bytes_sent, frames_sent, settings_cnt);
        $display("checked %0d payload bytes and %0d verdicts, %0d errors",
                 payload_cnt, verdict_cnt, err_cnt);
        if (err_cnt == 0)
            $display("stx_etx_frame_receiver_tb: done, clean");
        else
            $display("stx_etx_frame_receiver_tb: done, errors");
        $finish;
    end

endmodule
